// File: rtl/witsel_pkg.sv
// Shared constants, codes and helpers for the weighted interleave target select block.
`default_nettype none
package witsel_pkg;

	localparam int NUM_EXP     = 4;
	localparam int WEIGHT_BITS = 4;
	localparam int EXP_IDX_W   = $clog2(NUM_EXP);
	localparam int PAGES_W     = 32;
	localparam int CAP_W       = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int SLOTS       = 16;
	localparam int PTR_W       = $clog2(SLOTS);
	localparam int SLOT_W      = PTR_W + 1;
	localparam int CUM_W       = $clog2(NUM_EXP * ((1 << WEIGHT_BITS) - 1) + 1);
	localparam int MIB_SHIFT   = 20;
	localparam int WIDE_W      = PAGES_W + 30;
	localparam int USED_W      = WIDE_W - MIB_SHIFT;

	localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_CAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXP0_CAP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXP_LAST   = CFG_IDX_W'(3 + NUM_EXP - 1);

	localparam logic [1:0] KIND_LOCAL    = 2'd0;
	localparam logic [1:0] KIND_REMOTE   = 2'd1;
	localparam logic [1:0] KIND_ALL_FULL = 2'd2;

	localparam logic [1:0] PAGE_CODE_RESET = 2'd1;

	typedef logic [4:0] shift_t;
	localparam shift_t PAGE_SHIFT [4] = '{5'd6, 5'd12, 5'd21, 5'd30};

	// pages * page size in MiB
	function automatic logic [USED_W-1:0] used_mib(input logic [PAGES_W-1:0] pages,
		input logic [1:0] code);
		logic [WIDE_W-1:0] wide;
		wide = {{(WIDE_W-PAGES_W){1'b0}}, pages} << PAGE_SHIFT[code];
		return wide[WIDE_W-1:MIB_SHIFT];
	endfunction

	typedef struct packed {
		logic [PAGES_W-1:0] pages;
		logic [CAP_W-1:0]   cap;
		logic [1:0]         page_code;
		logic               is_local;
	} fit_req_t;

endpackage
`default_nettype wire

// File: rtl/weighted_interleave_target_select_core.sv
// Top level: config registers, round-robin walk sequencer and result register.
//
// Usage: each transfer on the input channel (in_valid/in_stall) carries the
// page counts for local memory and the four expanders; one result transfer
// (out_valid/out_stall) returns target_kind and expander_index.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written
// while the block is idle; page size code resets to 4 KiB, all else to zero.
// An item whose answer is local (below 90% local capacity, or zero weight
// sum) is answered from the check step and needs no walk. Otherwise the walk
// evaluates one weight slot per cycle, unless held on its final step, in a
// single shared capacity compare unit, visiting 1 to 16 slots; a start slot
// at or past the weight sum, as when the pointer wraps or after a weight
// change, is first folded back into range by subtracting the sum.
// One item is in work at a time; in_stall is high from acceptance until the
// result is written to the output register, so the next item may be taken
// while a finished result still waits. If the output register is still held
// by a stalled receiver, the local check or the walk waits on its final step.
// Reset clears the pointer, the sequencer and out_valid; a walk that finds
// every expander full answers all_full and leaves the pointer unchanged.
`default_nettype none
module weighted_interleave_target_select_core
	import witsel_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [PAGES_W-1:0]     local_used_pages,
	input  wire [PAGES_W-1:0]     exp0_used_pages,
	input  wire [PAGES_W-1:0]     exp1_used_pages,
	input  wire [PAGES_W-1:0]     exp2_used_pages,
	input  wire [PAGES_W-1:0]     exp3_used_pages,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [1:0]            target_kind,
	output logic [EXP_IDX_W-1:0]  expander_index
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]             state_q;
	logic [1:0]             page_code_q;
	logic [CAP_W-1:0]       local_cap_q;
	logic [WEIGHT_BITS-1:0] weight_q [NUM_EXP];
	logic [CAP_W-1:0]       exp_cap_q [NUM_EXP];
	logic [PTR_W-1:0]       ptr_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [PTR_W-1:0]       cnt_q;
	logic [PAGES_W-1:0]     local_pages_q;
	logic [PAGES_W-1:0]     exp_pages_q [NUM_EXP];
	logic                   out_valid_q;
	logic [1:0]             kind_q;
	logic [EXP_IDX_W-1:0]   idx_q;

	logic [CUM_W-1:0]       sum_raw;
	logic [SLOT_W-1:0]      sum;
	logic [EXP_IDX_W-1:0]   owner;
	logic [CUM_W-1:0]       cum;
	logic                   found;
	logic                   fits;
	logic                   out_free;
	logic                   out_load;
	logic                   in_xfer;
	logic [EXP_IDX_W-1:0]   cap_sel;
	logic [CFG_IDX_W-1:0]   cap_off;
	logic [SLOT_W-1:0]      slot_next;
	fit_req_t               fit_req;

	always_comb begin
		sum_raw = '0;
		cum     = '0;
		owner   = '0;
		found   = 1'b0;
		for (int i = 0; i < NUM_EXP; i++) begin
			sum_raw = sum_raw + CUM_W'(weight_q[i]);
		end
		sum = (sum_raw > CUM_W'(SLOTS)) ? SLOT_W'(SLOTS) : SLOT_W'(sum_raw);
		for (int i = 0; i < NUM_EXP; i++) begin
			cum = cum + CUM_W'(weight_q[i]);
			if (!found && cum > CUM_W'(slot_q)) begin
				found = 1'b1;
				owner = EXP_IDX_W'(i);
			end
		end
	end

	always_comb begin
		fit_req.page_code = page_code_q;
		fit_req.is_local  = (state_q == ST_CHECK);
		fit_req.pages     = fit_req.is_local ? local_pages_q : exp_pages_q[owner];
		fit_req.cap       = fit_req.is_local ? local_cap_q : exp_cap_q[owner];
	end

	witsel_fit_unit u_fit (
		.req  (fit_req),
		.fits (fits)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (((state_q == ST_CHECK) && (fits || sum == '0))
		|| ((state_q == ST_WALK) && (slot_q < sum)
		&& (fits || {1'b0, cnt_q} == sum - SLOT_W'(1))));
	assign cap_off   = cfg_index - REG_EXP0_CAP;
	assign cap_sel   = cap_off[EXP_IDX_W-1:0];
	assign slot_next = (slot_q + SLOT_W'(1) == sum) ? '0 : slot_q + SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_code_q <= PAGE_CODE_RESET;
			local_cap_q <= '0;
			for (int i = 0; i < NUM_EXP; i++) begin
				weight_q[i]  <= '0;
				exp_cap_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAGE_SIZE: page_code_q <= cfg_data[1:0];
				REG_LOCAL_CAP: local_cap_q <= cfg_data[CAP_W-1:0];
				REG_WEIGHTS: begin
					for (int i = 0; i < NUM_EXP; i++) begin
						weight_q[i] <= cfg_data[i*WEIGHT_BITS +: WEIGHT_BITS];
					end
				end
				default: begin
					if (cfg_index >= REG_EXP0_CAP && cfg_index <= REG_EXP_LAST) begin
						exp_cap_q[cap_sel] <= cfg_data[CAP_W-1:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			local_pages_q  <= local_used_pages;
			exp_pages_q[0] <= exp0_used_pages;
			exp_pages_q[1] <= exp1_used_pages;
			exp_pages_q[2] <= exp2_used_pages;
			exp_pages_q[3] <= exp3_used_pages;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			slot_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_LOCAL;
			idx_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (fits || sum == '0) begin
						if (out_free) begin
							kind_q      <= KIND_LOCAL;
							idx_q       <= '0;
							state_q     <= ST_IDLE;
						end
					end else begin
						slot_q  <= {1'b0, ptr_q} + SLOT_W'(1);
						cnt_q   <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (slot_q >= sum) begin
						slot_q <= slot_q - sum;
					end else if (fits) begin
						if (out_free) begin
							kind_q      <= KIND_REMOTE;
							idx_q       <= owner;
							ptr_q       <= slot_q[PTR_W-1:0];
							state_q     <= ST_IDLE;
						end
					end else if ({1'b0, cnt_q} == sum - SLOT_W'(1)) begin
						if (out_free) begin
							kind_q      <= KIND_ALL_FULL;
							idx_q       <= '0;
							state_q     <= ST_IDLE;
						end
					end else begin
						cnt_q  <= cnt_q + PTR_W'(1);
						slot_q <= slot_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign target_kind    = kind_q;
	assign expander_index = idx_q;

endmodule
`default_nettype wire

// File: rtl/witsel_fit_unit.sv
// Shared capacity test: local 90% threshold or expander below capacity.
`default_nettype none
module witsel_fit_unit
	import witsel_pkg::*;
(
	input  wire fit_req_t req,
	output logic        fits
);

	logic [USED_W-1:0] used;
	logic              over;
	logic [CAP_W-1:0]  used_lo;
	logic [CAP_W+3:0]  used_x10;
	logic [CAP_W+3:0]  cap_x9;

	always_comb begin
		used     = used_mib(req.pages, req.page_code);
		over     = |used[USED_W-1:CAP_W];
		used_lo  = used[CAP_W-1:0];
		used_x10 = {1'b0, used_lo, 3'b000} + {3'b000, used_lo, 1'b0};
		cap_x9   = {1'b0, req.cap, 3'b000} + {4'b0000, req.cap};
		if (over) begin
			fits = 1'b0;
		end else if (req.is_local) begin
			fits = used_x10 < cap_x9;
		end else begin
			fits = used_lo < req.cap;
		end
	end

endmodule
`default_nettype wire

// File: rtl/witsel_checker.sv
// Port-level checker for the target select core, bound to the top level.
`default_nettype none
module witsel_checker
	import witsel_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_stall,
	input wire                   out_valid,
	input wire                   out_stall,
	input wire [1:0]             target_kind,
	input wire [EXP_IDX_W-1:0]   expander_index
);

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_kind != KIND_REMOTE |-> expander_index == '0)
		else $error("expander_index nonzero for a non-remote result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_kind)
			&& $stable(expander_index))
		else $error("stalled result changed or dropped");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled while an item is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

endmodule

bind weighted_interleave_target_select_core witsel_checker u_witsel_checker (.*);
`default_nettype wire

// File: tb/weighted_interleave_target_select_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the weighted interleave target select core.
module weighted_interleave_target_select_core_test;
	import witsel_pkg::*;

	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int LONG_HOLD       = 400;
	localparam int LIMIT_CYCLES    = 1000000;
	localparam int DRAIN_CYCLES    = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_EXP_LAST + 1);
	localparam logic [CAP_W-1:0] CAP_MAX = '1;

	typedef struct packed {
		logic [PAGES_W-1:0]              local_pages;
		logic [NUM_EXP-1:0][PAGES_W-1:0] exp_pages;
	} page_req_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [EXP_IDX_W-1:0] idx;
	} placement_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PAGES_W-1:0]    local_used_pages = '0;
	logic [PAGES_W-1:0]    exp0_used_pages = '0;
	logic [PAGES_W-1:0]    exp1_used_pages = '0;
	logic [PAGES_W-1:0]    exp2_used_pages = '0;
	logic [PAGES_W-1:0]    exp3_used_pages = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            target_kind;
	logic [EXP_IDX_W-1:0]  expander_index;

	weighted_interleave_target_select_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.local_used_pages(local_used_pages),
		.exp0_used_pages(exp0_used_pages),
		.exp1_used_pages(exp1_used_pages),
		.exp2_used_pages(exp2_used_pages),
		.exp3_used_pages(exp3_used_pages),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.target_kind(target_kind),
		.expander_index(expander_index)
	);

	always #5 clk = ~clk;

	// placement predictor state
	logic [1:0]             pg_code = PAGE_CODE_RESET;
	logic [CAP_W-1:0]       local_cap = '0;
	logic [WEIGHT_BITS-1:0] exp_weight [NUM_EXP] = '{default: '0};
	logic [CAP_W-1:0]       exp_cap [NUM_EXP] = '{default: '0};
	logic [PTR_W-1:0]       rr_ptr = '0;

	page_req_t  page_reqs [$];
	placement_t placements_due [$];
	int         reqs_queued = 0;
	int         reqs_taken = 0;
	int         mismatches = 0;
	logic       req_xfer = 1'b0;
	logic       idle_mode = 1'b1;
	int         send_gap = 0;
	int         rx_run = 0;
	int         rx_hold_req = 0;
	int         rx_hold_seen = 0;
	page_req_t  drv_req;

	function automatic longint unsigned mib_of(logic [PAGES_W-1:0] pages);
		logic [63:0] wide;
		wide = 64'(pages) << PAGE_SHIFT[pg_code];
		return wide >> MIB_SHIFT;
	endfunction

	function automatic placement_t place_page(page_req_t r);
		placement_t res;
		int sum, slot, owner, cum, s, i;
		logic found;
		res.kind = KIND_LOCAL;
		res.idx = '0;
		found = 1'b0;
		sum = 0;
		for (i = 0; i < NUM_EXP; i++)
			sum += exp_weight[i];
		if (sum > SLOTS)
			sum = SLOTS;
		if (mib_of(r.local_pages) * 10 >= 64'(local_cap) * 9 && sum != 0) begin
			res.kind = KIND_ALL_FULL;
			slot = rr_ptr;
			for (s = 0; s < sum && !found; s++) begin
				slot = (slot + 1) % sum;
				owner = -1;
				cum = 0;
				for (i = 0; i < NUM_EXP; i++) begin
					cum += exp_weight[i];
					if (owner < 0 && cum > slot)
						owner = i;
				end
				if (mib_of(r.exp_pages[owner]) < 64'(exp_cap[owner])) begin
					found = 1'b1;
					rr_ptr = slot[PTR_W-1:0];
					res.kind = KIND_REMOTE;
					res.idx = owner[EXP_IDX_W-1:0];
				end
			end
		end
		return res;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_mode)
			return 0;
		if (r < 70)
			return $urandom_range(0, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// pages that give roughly the requested MiB at the current page size
	function automatic logic [PAGES_W-1:0] pages_for(longint mib);
		int sh;
		logic [63:0] p;
		sh = PAGE_SHIFT[pg_code];
		if (mib < 0)
			mib = 0;
		if (sh <= MIB_SHIFT)
			p = (64'(mib) << (MIB_SHIFT - sh)) |
				64'($urandom_range(0, (1 << (MIB_SHIFT - sh)) - 1));
		else
			p = 64'(mib) >> (sh - MIB_SHIFT);
		return p[PAGES_W-1:0];
	endfunction

	function automatic logic [PAGES_W-1:0] pages_near(longint edge_mib, int below_pct);
		int r;
		longint mib;
		r = $urandom_range(0, 99);
		if (r >= 90)
			return (r < 93) ? (r[0] ? '1 : '0) : PAGES_W'($urandom);
		if (r < below_pct)
			mib = (edge_mib > 0) ? longint'($urandom_range(0, edge_mib - 1)) : 0;
		else if (r < below_pct + 35)
			mib = edge_mib + longint'($urandom_range(0, 4)) - 2;
		else
			mib = edge_mib + longint'($urandom_range(1, edge_mib + 16));
		return pages_for(mib);
	endfunction

	function automatic page_req_t req_of(logic [PAGES_W-1:0] l, logic [PAGES_W-1:0] e0,
		logic [PAGES_W-1:0] e1, logic [PAGES_W-1:0] e2, logic [PAGES_W-1:0] e3);
		page_req_t q;
		q.local_pages = l;
		q.exp_pages[0] = e0;
		q.exp_pages[1] = e1;
		q.exp_pages[2] = e2;
		q.exp_pages[3] = e3;
		return q;
	endfunction

	function automatic page_req_t random_req();
		page_req_t q;
		int i;
		logic all_full;
		all_full = ($urandom_range(0, 99) < 8);
		q.local_pages = pages_near((longint'(local_cap) * 9 + 9) / 10, 25);
		for (i = 0; i < NUM_EXP; i++)
			q.exp_pages[i] = all_full ? pages_for(2 * longint'(exp_cap[i]) + 2048)
				: pages_near(exp_cap[i], 45);
		return q;
	endfunction

	function automatic logic [CAP_W-1:0] pick_cap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return CAP_MAX;
		if (r < 70)
			return CAP_W'($urandom_range(1, 4096));
		return CAP_W'($urandom_range(0, CAP_MAX));
	endfunction

	function automatic logic [15:0] pick_weights();
		int r, rem, i;
		logic [15:0] w;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 15)
			return '1;
		if (r < 22)
			return 16'($urandom_range(0, 16'hFFFF));
		rem = $urandom_range(1, 10);
		for (i = 0; i < NUM_EXP; i++) begin
			w[i*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom_range(0, rem));
			rem -= w[i*WEIGHT_BITS +: WEIGHT_BITS];
		end
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int i;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PAGE_SIZE: pg_code = val[1:0];
			REG_LOCAL_CAP: local_cap = val[CAP_W-1:0];
			REG_WEIGHTS: begin
				for (i = 0; i < NUM_EXP; i++)
					exp_weight[i] = val[i*WEIGHT_BITS +: WEIGHT_BITS];
			end
			default: begin
				if (idx >= REG_EXP0_CAP && idx <= REG_EXP_LAST)
					exp_cap[EXP_IDX_W'(idx - REG_EXP0_CAP)] = val[CAP_W-1:0];
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] code, input logic [CAP_W-1:0] lcap,
		input logic [15:0] w, input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
		input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3);
		write_reg(REG_PAGE_SIZE, CFG_DATA_W'(code));
		write_reg(REG_LOCAL_CAP, lcap);
		write_reg(REG_WEIGHTS, CFG_DATA_W'(w));
		write_reg(REG_EXP0_CAP, c0);
		write_reg(CFG_IDX_W'(REG_EXP0_CAP + 1), c1);
		write_reg(CFG_IDX_W'(REG_EXP0_CAP + 2), c2);
		write_reg(CFG_IDX_W'(REG_EXP0_CAP + 3), c3);
	endtask

	task automatic queue_req(input page_req_t q);
		page_reqs = {page_reqs, q};
		reqs_queued++;
	endtask

	task automatic settle();
		while (reqs_taken != reqs_queued || placements_due.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!in_valid || req_xfer) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (page_reqs.size() > 0) begin
				drv_req = page_reqs.pop_front();
				local_used_pages <= drv_req.local_pages;
				exp0_used_pages <= drv_req.exp_pages[0];
				exp1_used_pages <= drv_req.exp_pages[1];
				exp2_used_pages <= drv_req.exp_pages[2];
				exp3_used_pages <= drv_req.exp_pages[3];
				in_valid <= 1'b1;
				send_gap <= ($urandom_range(0, 1) == 1) ? idle_len() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		if (rx_hold_seen != rx_hold_req) begin
			rx_hold_seen <= rx_hold_req;
			rx_run <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (rx_run > 0) begin
			rx_run <= rx_run - 1;
		end else begin
			out_stall <= idle_mode && ($urandom_range(0, 2) == 0);
			rx_run <= idle_len();
		end
	end

	// monitor: check results, predict on each accepted request
	always @(posedge clk) begin
		placement_t due;
		req_xfer <= in_valid && !in_stall;
		if (out_valid && !out_stall) begin
			if (placements_due.size() == 0) begin
				$display("%0t: unexpected transfer kind=%0d index=%0d", $time,
					target_kind, expander_index);
				mismatches++;
			end else begin
				due = placements_due.pop_front();
				if (target_kind !== due.kind) begin
					$display("%0t: target_kind expected %0d actual %0d", $time,
						due.kind, target_kind);
					mismatches++;
				end
				if (expander_index !== due.idx) begin
					$display("%0t: expander_index expected %0d actual %0d", $time,
						due.idx, expander_index);
					mismatches++;
				end
			end
		end
		if (in_valid && !in_stall) begin
			placements_due = {placements_due, place_page(req_of(local_used_pages,
				exp0_used_pages, exp1_used_pages, exp2_used_pages, exp3_used_pages))};
			reqs_taken++;
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("weighted_interleave_target_select_core_test: errors");
		$finish;
	end

	initial begin
		int k, n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset config: zero weight sum, always local
		queue_req(req_of('0, '0, '0, '0, '0));
		queue_req(req_of('1, '1, '1, '1, '1));
		settle();

		// 4 KiB pages, weights 4/3/2/1
		configure(2'd1, 20'd1000, 16'h1234, 20'd100, 20'd200, 20'd300, 20'd400);
		queue_req(req_of('0, '0, '0, '0, '0));
		queue_req(req_of('1, '0, '0, '0, '0));
		queue_req(req_of(32'd900 << 8, '0, '0, '0, '0));
		queue_req(req_of((32'd900 << 8) - 1, '0, '0, '0, '0));
		queue_req(req_of('1, 32'd100 << 8, '0, '0, '0));
		queue_req(req_of('1, (32'd100 << 8) - 1, '1, '1, '1));
		queue_req(req_of('1, '1, '1, '1, '1));
		queue_req(req_of('1, '1, '1, '1, '0));
		queue_req(req_of('1, '1, '1, '0, '1));
		queue_req(req_of('1, '1, 32'd200 << 8, (32'd300 << 8) - 1, '1));
		settle();

		// zero weight sum with zero local capacity
		configure(2'd0, '0, 16'h0000, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX);
		queue_req(req_of('1, '0, '0, '0, '0));
		queue_req(req_of('0, '1, '1, '1, '1));
		settle();

		// weight sum clamped to the pointer range
		configure(2'd3, CAP_MAX, 16'hFFFF, CAP_MAX, CAP_MAX, CAP_MAX, CAP_MAX);
		queue_req(req_of(32'd921, '0, '0, '0, '0));
		queue_req(req_of(32'd922, '0, '0, '0, '0));
		for (n = 0; n < 4; n++)
			queue_req(req_of('1, '0, '0, '0, '0));
		queue_req(req_of('1, '1, '1, '1, '1));
		settle();

		// sum shrinks below the pointer; spare index is ignored
		write_reg(REG_SPARE, '1);
		configure(2'd2, 20'd1, 16'h0011, '0, 20'd5, '0, '0);
		queue_req(req_of(32'd1, '0, '0, '0, '0));
		queue_req(req_of('1, '0, '0, '1, '1));
		queue_req(req_of('0, '1, '1, '1, '1));
		settle();

		for (k = 0; k < RAND_PHASES; k++) begin
			idle_mode <= (k % 4 != 3);
			configure(2'(k % 4), pick_cap(), pick_weights(), pick_cap(), pick_cap(),
				pick_cap(), pick_cap());
			if (k == 2 || k == 7)
				rx_hold_req <= rx_hold_req + 1;
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				queue_req(random_req());
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("weighted_interleave_target_select_core_test: clean");
		else
			$display("weighted_interleave_target_select_core_test: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/witsel_pkg.sv
rtl/witsel_fit_unit.sv
rtl/weighted_interleave_target_select_core.sv
rtl/witsel_checker.sv
tb/weighted_interleave_target_select_core_test.sv
